// ===== rtl/core/isoe_pkg.sv =====
// ----------------------------------------------------------------------------
// isoe_pkg
// Shared types and codes for the integer set operation engine.
// ----------------------------------------------------------------------------
package isoe_pkg;

   localparam int unsigned DefMaxElems = 32;
   localparam int unsigned DataW = 32;

   // request opcodes
   typedef enum logic [2:0] {
      OP_LOAD_A = 3'd0,
      OP_LOAD_B = 3'd1,
      OP_UNION  = 3'd2,
      OP_ISECT  = 3'd3,
      OP_AMB    = 3'd4,
      OP_BMA    = 3'd5,
      OP_SYMD   = 3'd6,
      OP_CLEAR  = 3'd7
   } opcode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_ELEM  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_TEST,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DataW-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0]  element;
      logic                     last;
      logic [1:0]               status;
   } rsp_type;

   // match flags returned by one cell
   typedef struct packed {
      logic a;
      logic a_lo;
      logic b;
      logic b_lo;
   } hit_type;

endpackage

// ===== rtl/core/isoe_cell.sv =====
// ----------------------------------------------------------------------------
// isoe_cell
// One slot of lists A and B with a compare against the broadcast key.
// ----------------------------------------------------------------------------
module isoe_cell #(
   parameter int unsigned SLOT  = 0,
   parameter int unsigned IDX_W = 5,
   parameter int unsigned CNT_W = 6
) (
   input  logic                           clock,
   input  logic                           we_a,
   input  logic                           we_b,
   input  logic [isoe_pkg::DataW-1:0]     wr_data,
   input  logic [isoe_pkg::DataW-1:0]     key,
   input  logic [IDX_W-1:0]               idx,
   input  logic [CNT_W-1:0]               cnt_a,
   input  logic [CNT_W-1:0]               cnt_b,
   output logic [isoe_pkg::DataW-1:0]     a_val,
   output logic [isoe_pkg::DataW-1:0]     b_val,
   output isoe_pkg::hit_type              hit
);
   import isoe_pkg::*;

   localparam logic [CNT_W-1:0] SlotC = CNT_W'(SLOT);

   logic [DataW-1:0] a_ff;
   logic [DataW-1:0] b_ff;
   logic             lo;

   // slot storage
   always_ff @(posedge clock) begin
      if (we_a) a_ff <= wr_data;
      if (we_b) b_ff <= wr_data;
   end

   assign a_val = a_ff;
   assign b_val = b_ff;

   // compare against key, qualified by fill and walk position
   assign lo = SlotC < {1'b0, idx};
   always_comb begin
      hit.a    = (a_ff == key) && (SlotC < cnt_a);
      hit.b    = (b_ff == key) && (SlotC < cnt_b);
      hit.a_lo = hit.a && lo;
      hit.b_lo = hit.b && lo;
   end

endmodule

// ===== rtl/core/integer_set_operation_engine_top.sv =====
// ----------------------------------------------------------------------------
// integer_set_operation_engine_top
// Loads lists A and B into a row of cells and walks them to emit set results.
// ----------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  req      in         req_type  req_valid / req_stall
//  rsp      out        rsp_type  rsp_valid / rsp_stall
//
// loads and clears complete in the idle state; a compute request walks one
// list (intersect, a-b, b-a) or both lists (union, symdiff), handling each
// walked element as a key fetch, then a parallel compare across all cells,
// and waits on rsp_stall.
// reset clears counts and control; list contents are undefined until loaded.
// a stalled response holds the walk when a new element must be pushed.
module integer_set_operation_engine_top #(
   parameter int unsigned MAX_ELEMS = isoe_pkg::DefMaxElems
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  isoe_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output isoe_pkg::rsp_type  rsp_data
);
   import isoe_pkg::*;

   localparam int unsigned IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CapC = CNT_W'(MAX_ELEMS);

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   logic             side_ff, side_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DataW-1:0] key_ff, key_in;
   logic [DataW-1:0] pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic [DataW-1:0] a_vals [MAX_ELEMS];
   logic [DataW-1:0] b_vals [MAX_ELEMS];
   hit_type          hits [MAX_ELEMS];
   logic [MAX_ELEMS-1:0] we_a, we_b;

   logic       out_free, accept, any_a, any_b, dup_a, dup_b;
   logic       emit, blocked, side_end, need_b;
   logic [CNT_W-1:0] cur_cnt;
   opcode_type req_op;

   assign req_op    = opcode_type'(req_data.opcode);
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // cell row
   for (genvar j = 0; j < MAX_ELEMS; j++) begin : g_cell
      assign we_a[j] = accept && (req_op == OP_LOAD_A) && (cnt_a_ff == CNT_W'(j));
      assign we_b[j] = accept && (req_op == OP_LOAD_B) && (cnt_b_ff == CNT_W'(j));
      isoe_cell #(.SLOT(j), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_cell (
         .clock   (clock),
         .we_a    (we_a[j]),
         .we_b    (we_b[j]),
         .wr_data (req_data.value),
         .key     (key_ff),
         .idx     (idx_ff),
         .cnt_a   (cnt_a_ff),
         .cnt_b   (cnt_b_ff),
         .a_val   (a_vals[j]),
         .b_val   (b_vals[j]),
         .hit     (hits[j])
      );
   end

   // reduce match flags
   always_comb begin
      any_a = 1'b0;
      any_b = 1'b0;
      dup_a = 1'b0;
      dup_b = 1'b0;
      for (int j = 0; j < MAX_ELEMS; j++) begin
         any_a = any_a | hits[j].a;
         any_b = any_b | hits[j].b;
         dup_a = dup_a | hits[j].a_lo;
         dup_b = dup_b | hits[j].b_lo;
      end
   end

   // emit decision for the current key
   always_comb begin
      emit = 1'b0;
      if (!side_ff) begin
         case (op_ff)
            OP_UNION: emit = !dup_a;
            OP_ISECT: emit = any_b;
            OP_AMB:   emit = !any_b;
            OP_SYMD:  emit = !any_b && !dup_a;
            default:  emit = 1'b0;
         endcase
      end else begin
         case (op_ff)
            OP_UNION: emit = !any_a && !dup_b;
            OP_BMA:   emit = !any_a;
            OP_SYMD:  emit = !any_a && !dup_b;
            default:  emit = 1'b0;
         endcase
      end
   end

   assign cur_cnt  = side_ff ? cnt_b_ff : cnt_a_ff;
   assign side_end = ({1'b0, idx_ff} + CNT_W'(1)) == cur_cnt;
   assign need_b   = !side_ff && ((op_ff == OP_UNION) || (op_ff == OP_SYMD));
   assign blocked  = emit && pend_vld_ff && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_op inside {OP_UNION, OP_ISECT, OP_AMB, OP_BMA, OP_SYMD}))
               state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cur_cnt != '0) state_in = S_FETCH;
            else if (!need_b)  state_in = S_DONE;
         end
         S_FETCH: state_in = S_TEST;
         S_TEST: begin
            if (!blocked) begin
               if (!side_end)    state_in = S_FETCH;
               else if (need_b)  state_in = S_CHECK;
               else              state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in       = op_ff;
      side_in     = side_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = out_free ? 1'b0 : rsp_vld_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               side_in     = (req_op == OP_BMA);
               idx_in      = '0;
               pend_vld_in = 1'b0;
               case (req_op)
                  OP_LOAD_A: begin
                     if (cnt_a_ff >= CapC) begin
                        rsp_in     = '{element: req_data.value, last: 1'b1,
                                       status: ST_FULL};
                        rsp_vld_in = 1'b1;
                     end else cnt_a_in = cnt_a_ff + CNT_W'(1);
                  end
                  OP_LOAD_B: begin
                     if (cnt_b_ff >= CapC) begin
                        rsp_in     = '{element: req_data.value, last: 1'b1,
                                       status: ST_FULL};
                        rsp_vld_in = 1'b1;
                     end else cnt_b_in = cnt_b_ff + CNT_W'(1);
                  end
                  OP_CLEAR: begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            idx_in = '0;
            if ((cur_cnt == '0) && need_b) side_in = 1'b1;
         end
         S_FETCH: key_in = side_ff ? b_vals[idx_ff] : a_vals[idx_ff];
         S_TEST: begin
            if (!blocked) begin
               if (emit) begin
                  if (pend_vld_ff) begin
                     rsp_in     = '{element: pend_ff, last: 1'b0, status: ST_ELEM};
                     rsp_vld_in = 1'b1;
                  end
                  pend_in     = key_ff;
                  pend_vld_in = 1'b1;
               end
               if (!side_end) idx_in = idx_ff + IDX_W'(1);
               else if (need_b) begin
                  side_in = 1'b1;
                  idx_in  = '0;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               if (pend_vld_ff)
                  rsp_in = '{element: pend_ff, last: 1'b1, status: ST_ELEM};
               else
                  rsp_in = '{element: '0, last: 1'b1, status: ST_EMPTY};
               pend_vld_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_a_ff    <= '0;
         cnt_b_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_a_ff    <= cnt_a_in;
         cnt_b_ff    <= cnt_b_in;
         rsp_vld_ff  <= rsp_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      side_ff <= side_in;
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== dv/tb_integer_set_operation_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_integer_set_operation_engine_top
// Self-checking bench for the set engine: loads lists A and B, runs every set
// operation and clear, and compares each response with a local set predictor.
// ----------------------------------------------------------------------------
module tb_integer_set_operation_engine_top;
   timeunit 1ns;
   timeprecision 1ps;
   import isoe_pkg::*;

   localparam int unsigned Cap = DefMaxElems;
   localparam int unsigned IdleLimit = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   integer_set_operation_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state
   logic [31:0] list_a[$];
   logic [31:0] list_b[$];
   rsp_type     expected_rsp[$];
   req_type     pending_req[$];
   int          hold_marks[$];   // request indexes at which the sender drains
   int          sent_count;
   int          errors;
   int          idle_cycles;
   bit          stim_done;
   bit          draining;
   int          burst_left;
   int          gap_left;
   int          stall_phase;

   function automatic bit in_list(ref logic [31:0] l[$], input logic [31:0] v);
      foreach (l[i]) if (l[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   // set result of one request, appended to the expected responses
   task automatic predict_set_result(input req_type r);
      logic [31:0] found[$];
      rsp_type     x;
      opcode_type  op;
      op = opcode_type'(r.opcode);
      case (op)
         OP_LOAD_A, OP_LOAD_B: begin
            if ((op == OP_LOAD_A ? list_a.size() : list_b.size()) >= Cap) begin
               x.element = r.value; x.last = 1'b1; x.status = ST_FULL;
               expected_rsp.push_back(x);
            end else if (op == OP_LOAD_A) list_a.push_back(r.value);
            else list_b.push_back(r.value);
            return;
         end
         OP_CLEAR: begin
            list_a.delete(); list_b.delete();
            return;
         end
         OP_UNION: begin
            foreach (list_a[i]) if (!in_list(found, list_a[i])) found.push_back(list_a[i]);
            foreach (list_b[i]) if (!in_list(found, list_b[i])) found.push_back(list_b[i]);
         end
         OP_ISECT:
            foreach (list_a[i]) if (in_list(list_b, list_a[i])) found.push_back(list_a[i]);
         OP_AMB:
            foreach (list_a[i]) if (!in_list(list_b, list_a[i])) found.push_back(list_a[i]);
         OP_BMA:
            foreach (list_b[i]) if (!in_list(list_a, list_b[i])) found.push_back(list_b[i]);
         default: begin
            foreach (list_a[i])
               if (!in_list(list_b, list_a[i]) && !in_list(found, list_a[i]))
                  found.push_back(list_a[i]);
            foreach (list_b[i])
               if (!in_list(list_a, list_b[i]) && !in_list(found, list_b[i]))
                  found.push_back(list_b[i]);
         end
      endcase
      if (found.size() == 0) begin
         x.element = '0; x.last = 1'b1; x.status = ST_EMPTY;
         expected_rsp.push_back(x);
      end else
         foreach (found[i]) begin
            x.element = found[i];
            x.last = (i == found.size() - 1);
            x.status = ST_ELEM;
            expected_rsp.push_back(x);
         end
   endtask

   function automatic req_type mk(input opcode_type op, input logic [31:0] v);
      req_type r;
      r.opcode = op;
      r.value = v;
      return r;
   endfunction

   // value from a small pool so sets overlap, sometimes fully random
   function automatic logic [31:0] pick_value();
      logic [31:0] pool[6] = '{32'h0, 32'h1, 32'h8000_0000, 32'h7fff_ffff,
                               32'hffff_ffff, 32'h5a5a_a5a5};
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return pool[$urandom_range(0, 5)];
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stimulus
   initial begin
      int n;
      int i;
      opcode_type op;
      // empty stores, every operation
      for (i = OP_UNION; i <= OP_SYMD; i++) pending_req.push_back(mk(opcode_type'(i), 0));
      // field extremes and overlap
      pending_req.push_back(mk(OP_LOAD_A, 32'h8000_0000));
      pending_req.push_back(mk(OP_LOAD_A, 32'h7fff_ffff));
      pending_req.push_back(mk(OP_LOAD_A, 32'h7fff_ffff));
      pending_req.push_back(mk(OP_LOAD_A, 32'hffff_ffff));
      pending_req.push_back(mk(OP_LOAD_B, 32'h7fff_ffff));
      pending_req.push_back(mk(OP_LOAD_B, 32'h0));
      pending_req.push_back(mk(OP_LOAD_B, 32'h0));
      for (i = OP_UNION; i <= OP_SYMD; i++) pending_req.push_back(mk(opcode_type'(i), $urandom));
      pending_req.push_back(mk(OP_CLEAR, 32'h1234));
      pending_req.push_back(mk(OP_ISECT, 0));
      hold_marks.push_back(pending_req.size());
      // fill A and B past capacity: store-full drop
      for (i = 0; i < Cap + 2; i++) pending_req.push_back(mk(OP_LOAD_A, i * 3));
      for (i = 0; i < Cap + 1; i++) pending_req.push_back(mk(OP_LOAD_B, i * 2));
      pending_req.push_back(mk(OP_UNION, 0));
      pending_req.push_back(mk(OP_SYMD, 0));
      pending_req.push_back(mk(OP_CLEAR, 0));
      // random sequences: loads, then computes, sometimes a clear
      n = 0;
      while (n < 360) begin
         if ($urandom_range(0, 9) == 0) hold_marks.push_back(pending_req.size());
         repeat ($urandom_range(0, 8)) begin
            op = $urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B;
            pending_req.push_back(mk(op, pick_value()));
            n++;
         end
         repeat ($urandom_range(1, 3)) begin
            pending_req.push_back(mk(opcode_type'($urandom_range(OP_UNION, OP_SYMD)),
                                     $urandom));
            n++;
         end
         if ($urandom_range(0, 3) == 0) begin
            pending_req.push_back(mk(OP_CLEAR, $urandom));
            n++;
         end
      end
   end

   // reset
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts with gaps, drains at hold marks
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         sent_count <= 0;
         burst_left <= 0;
         gap_left <= 0;
         draining <= 1'b0;
         stim_done <= 1'b0;
      end else begin
         logic accepted;
         logic want;
         accepted = req_valid && !req_stall;
         if (accepted) begin
            predict_set_result(req_data);
            void'(pending_req.pop_front());
            sent_count <= sent_count + 1;
         end
         if (!req_valid || accepted) begin
            want = 1'b0;
            if (hold_marks.size() > 0 && hold_marks[0] == sent_count + accepted) begin
               if (expected_rsp.size() == 0 && !rsp_valid) void'(hold_marks.pop_front());
            end else if (pending_req.size() > 0) begin
               if (gap_left > 0) gap_left <= gap_left - 1;
               else if (burst_left > 0) begin
                  want = 1'b1;
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 12);
                  gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
               end
            end else stim_done <= 1'b1;
            req_valid <= want;
            if (want) req_data <= pending_req[0];
         end
      end
   end

   // receiver stall pattern and response checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         errors <= 0;
         idle_cycles <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase / 64) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%t unexpected response: expected none, actual %h", $realtime,
                        rsp_data);
               errors <= errors + 1;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.element !== e.element || rsp_data.last !== e.last ||
                   rsp_data.status !== e.status) begin
                  $display("%t mismatch: expected elem %h last %b st %0d, actual elem %h last %b st %0d",
                           $realtime, e.element, e.last, e.status,
                           rsp_data.element, rsp_data.last, rsp_data.status);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= IdleLimit) begin
            $display("timeout with %0d responses outstanding", expected_rsp.size());
            $display("** integer_set_operation_engine_top: FAILED **");
            $finish;
         end
         if (stim_done && expected_rsp.size() == 0 && !req_valid) begin
            repeat (200) @(posedge clock);
            if (errors == 0 && expected_rsp.size() == 0)
               $display("** integer_set_operation_engine_top: PASSED **");
            else
               $display("** integer_set_operation_engine_top: FAILED **");
            $finish;
         end
      end
   end
endmodule
